// File: rtl/core/spq_pkg.sv
package spq_pkg;

   parameter int DEFAULT_CAPACITY    = 8;
   parameter int DEFAULT_VALUE_WIDTH = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_REM_HEAD,
      ST_REM_SHIFT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      ADDR_ZERO,
      ADDR_SLOT,
      ADDR_SLOT_M1,
      ADDR_SLOT_M2,
      ADDR_SLOT_P1
   } addr_sel_type;

   typedef enum logic [1:0] {
      SLOT_HOLD,
      SLOT_DEC,
      SLOT_INC,
      SLOT_ONE
   } slot_op_type;

   typedef struct packed {
      logic         load;
      logic         rd_en;
      addr_sel_type rd_sel;
      logic         wr_en;
      addr_sel_type wr_sel;
      logic         wr_value;
      slot_op_type  slot_op;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         take_removed;
      logic         set_status;
      status_type   status;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   slot_zero;
      logic   slot_one;
      logic   slot_last;
      logic   head_last;
      logic   ge;
      logic   rsp_free;
   } stat_type;

endpackage

// File: rtl/core/spq_ctrl.sv
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = ADDR_ZERO;
      cmd.wr_sel    = ADDR_SLOT;
      cmd.slot_op   = SLOT_HOLD;
      cmd.status    = STATUS_DONE;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.op == OP_INSERT) begin
               if (stat.full) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STATUS_OVERFLOW;
                  state_in       = ST_FINISH;
               end else if (stat.slot_zero) begin
                  cmd.wr_en    = 1'b1;
                  cmd.wr_sel   = ADDR_SLOT;
                  cmd.wr_value = 1'b1;
                  cmd.cnt_inc  = 1'b1;
                  state_in     = ST_FINISH;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = ADDR_SLOT_M1;
                  state_in   = ST_INS_CMP;
               end
            end else begin
               if (stat.empty) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STATUS_EMPTY;
                  state_in       = ST_FINISH;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = ADDR_ZERO;
                  cmd.slot_op = SLOT_ONE;
                  state_in    = ST_REM_HEAD;
               end
            end
         end
         ST_INS_CMP: begin
            if (stat.ge) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = ADDR_SLOT;
               cmd.slot_op = SLOT_DEC;
               if (stat.slot_one) begin
                  state_in = ST_INS_PUT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = ADDR_SLOT_M2;
               end
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = ADDR_SLOT;
               cmd.wr_value = 1'b1;
               cmd.cnt_inc  = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_INS_PUT: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = ADDR_SLOT;
            cmd.wr_value = 1'b1;
            cmd.cnt_inc  = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_REM_HEAD: begin
            cmd.take_removed = 1'b1;
            if (stat.head_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_SLOT;
               state_in   = ST_REM_SHIFT;
            end
         end
         ST_REM_SHIFT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ADDR_SLOT_M1;
            if (stat.slot_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = ADDR_SLOT_P1;
               cmd.slot_op = SLOT_INC;
            end
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/spq_datapath.sv
module spq_datapath #(
   parameter int CAPACITY    = spq_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = spq_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  spq_pkg::cmd_type                  cmd,
   output spq_pkg::stat_type                 stat,
   input  spq_pkg::op_type                   req_operation,
   input  logic signed [VALUE_WIDTH-1:0]     req_value_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output spq_pkg::status_type               rsp_status,
   output logic signed [VALUE_WIDTH-1:0]     rsp_removed_value,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_entry_count
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   logic signed [VALUE_WIDTH-1:0] store_ff [CAPACITY];

   op_type                        op_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic [CW-1:0]                 slot_ff;
   logic [CW-1:0]                 slot_in;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic signed [VALUE_WIDTH-1:0] removed_ff;
   status_type                    status_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   status_type                    rsp_status_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_removed_ff;
   logic [CW-1:0]                 rsp_count_ff;
   logic [AW-1:0]                 rd_addr;
   logic [AW-1:0]                 wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;

   function automatic logic [AW-1:0] addr_of(input addr_sel_type sel,
                                             input logic [CW-1:0] slot);
      logic [CW-1:0] a;
      case (sel)
         ADDR_ZERO:    a = '0;
         ADDR_SLOT:    a = slot;
         ADDR_SLOT_M1: a = slot - CW'(1);
         ADDR_SLOT_M2: a = slot - CW'(2);
         ADDR_SLOT_P1: a = slot + CW'(1);
         default:      a = '0;
      endcase
      return a[AW-1:0];
   endfunction

   always_comb begin
      rd_addr = addr_of(cmd.rd_sel, slot_ff);
      wr_addr = addr_of(cmd.wr_sel, slot_ff);
      wr_data = cmd.wr_value ? value_ff : rd_data_ff;
   end

   // sorted store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_comb begin
      case (cmd.slot_op)
         SLOT_HOLD: slot_in = slot_ff;
         SLOT_DEC:  slot_in = slot_ff - CW'(1);
         SLOT_INC:  slot_in = slot_ff + CW'(1);
         SLOT_ONE:  slot_in = CW'(1);
         default:   slot_in = slot_ff;
      endcase
      if (cmd.load) begin
         slot_in = count_ff;
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (cmd.load) begin
         op_ff      <= req_operation;
         value_ff   <= req_value_in;
         removed_ff <= '0;
         status_ff  <= STATUS_DONE;
      end else begin
         if (cmd.take_removed) begin
            removed_ff <= rd_data_ff;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
      end
      if (cmd.rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_count_ff   <= count_ff;
      end
   end

   always_comb begin
      stat.op        = op_ff;
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.empty     = (count_ff == '0);
      stat.slot_zero = (slot_ff == '0);
      stat.slot_one  = (slot_ff == CW'(1));
      stat.slot_last = ((slot_ff + CW'(1)) == count_ff);
      stat.head_last = (slot_ff == count_ff);
      stat.ge        = (rd_data_ff >= value_ff);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

// File: rtl/core/sorted_array_priority_queue.sv
// ascending priority queue held in a sorted, compacted store
// req channel: req_operation (insert or remove smallest) and req_value_in,
//   taken on req_valid and req_ready; one word is worked on at a time
// rsp channel: rsp_status, rsp_removed_value and rsp_entry_count, one word
//   for every request word, held in an output register until rsp_ready
// insert walks down from the top entry, shifting one slot per cycle until
//   the new value finds its place; remove reads slot zero, then moves each
//   remaining entry down one slot per cycle
// a refused request or an insert into an empty store needs no walk; an
//   insert below every entry or a removal from a full store walks the
//   whole store;
//   the store's single read and single write port set one slot per cycle
// a request may be accepted while the previous result still waits; a
//   stalled rsp side holds the finished result and the next one waits
//   until the output register frees
// reset empties the queue and drops any pending result; store contents
//   need no clearing, as only slots below the count are ever read
module sorted_array_priority_queue #(
   parameter int CAPACITY    = spq_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = spq_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  spq_pkg::op_type                   req_operation,
   input  logic signed [VALUE_WIDTH-1:0]     req_value_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output spq_pkg::status_type               rsp_status,
   output logic signed [VALUE_WIDTH-1:0]     rsp_removed_value,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_entry_count
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   cmd_type  cmd;
   stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_value_in      (req_value_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count)
   );

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CW'(CAPACITY)))
      else $error("entry count beyond capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OVERFLOW) |->
      (rsp_entry_count == CW'(CAPACITY) && rsp_removed_value == '0))
      else $error("overflow reported on a store that is not full");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |->
      (rsp_entry_count == '0 && rsp_removed_value == '0))
      else $error("empty reported on a store holding entries");
`endif

endmodule
